// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_ZERO  = 6'b100000
    } state_t;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- rtl/sha256_message_hasher.sv -----
// SHA-256 hasher over a byte stream.
// Input channel (in_valid/in_ready): each transfer carries data_byte, has_byte
// and last. A transfer with has_byte set appends one byte to the message; a
// transfer with last set closes the message, appends padding and the bit
// length, and produces the 256-bit digest.
// Output channel (out_valid/out_ready): after a last transfer four transfers
// deliver the digest as 64-bit words, big-endian, word_index 0 to 3, with
// last_word set on the fourth. The block then restarts from the initial vector.
// A byte that does not fill the block leaves in_ready high for the next byte. A
// byte that fills the 64-byte block starts one compression: 64 rounds of the single
// shared round unit and then a fold, during which in_ready is low.
// A last transfer runs one or two compressions (two when fewer than nine bytes
// remain in the block). Padding is written into the buffer one byte per cycle,
// and the length block ends with one write of the 64-bit length into words 14
// and 15. The first digest word is valid once the last fold has updated the
// chaining words.
// A stalled receiver simply holds the block in the output state; no input is
// taken until all four words have left and the restart state has passed.
// Reset: asynchronous, active low; chaining words return to the initial
// vector, counters clear, the block buffer content is left as it was.
module sha256_message_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    sha256_pkg::state_t state_reg, state_next;

    // Block buffer holding 16 big-endian words; the schedule window reuses it.
    logic [31:0] w_mem [16];

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [5:0]  round_reg;
    logic [1:0]  widx_reg;
    logic        final_reg;   // message closed; padding/length pending
    logic        len_done_reg; // last block holds the length
    logic        pad_done_reg; // the 0x80 pad byte has been placed

    logic        in_fire;
    logic        out_fire;
    logic        pad_end;
    logic [31:0] wt;
    logic [31:0] w_new;
    logic [31:0] t1, t2;
    logic [31:0] s0, s1, big0, big1, ch, maj;
    logic [3:0]  ri;
    logic [63:0] bit_len;

    assign in_ready  = (state_reg == sha256_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state_reg == sha256_pkg::ST_OUT);
    assign out_fire  = out_valid && out_ready;
    assign bit_len   = {count_reg, 3'b000};
    // The padding of a block ends at its last byte or, in the length block,
    // at the cycle that writes the length.
    assign pad_end   = (fill_reg == 6'd63) ||
                       (pad_done_reg && fill_reg == sha256_pkg::LEN_POS);

    always_comb
    begin
        ri = round_reg[3:0];
        s0 = sha256_pkg::ror(w_mem[ri + 4'd1], 7) ^ sha256_pkg::ror(w_mem[ri + 4'd1], 18)
             ^ (w_mem[ri + 4'd1] >> 3);
        s1 = sha256_pkg::ror(w_mem[ri + 4'd14], 17) ^ sha256_pkg::ror(w_mem[ri + 4'd14], 19)
             ^ (w_mem[ri + 4'd14] >> 10);
        w_new = w_mem[ri] + s0 + w_mem[ri + 4'd9] + s1;
        wt = (round_reg < 6'd16) ? w_mem[ri] : w_new;
        big1 = sha256_pkg::ror(v_reg[4], 6) ^ sha256_pkg::ror(v_reg[4], 11)
               ^ sha256_pkg::ror(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + sha256_pkg::ROUND_K[round_reg] + wt;
        big0 = sha256_pkg::ror(v_reg[0], 2) ^ sha256_pkg::ror(v_reg[0], 13)
               ^ sha256_pkg::ror(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_byte && fill_reg == 6'd63)
                        state_next = sha256_pkg::ST_ROUND;
                    else if (last)
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (pad_end)
                    state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = sha256_pkg::ST_FOLD;
            end
            sha256_pkg::ST_FOLD:
            begin
                if (!final_reg)
                    state_next = sha256_pkg::ST_IDLE;
                else if (len_done_reg)
                    state_next = sha256_pkg::ST_OUT;
                else
                    state_next = sha256_pkg::ST_PAD;
            end
            sha256_pkg::ST_OUT:
            begin
                if (out_fire && widx_reg == 2'd3)
                    state_next = sha256_pkg::ST_ZERO;
            end
            sha256_pkg::ST_ZERO:
                state_next = sha256_pkg::ST_IDLE;
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // Byte write into a word of the buffer.
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[8 * (3 - pos) +: 8] = b;
        put_byte = r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (in_fire && has_byte)
            w_mem[fill_reg[5:2]] <= put_byte(w_mem[fill_reg[5:2]], fill_reg[1:0], data_byte);
        else if (state_reg == sha256_pkg::ST_PAD)
        begin
            if (pad_done_reg && fill_reg == sha256_pkg::LEN_POS)
            begin
                w_mem[14] <= bit_len[63:32];
                w_mem[15] <= bit_len[31:0];
            end
            else
                w_mem[fill_reg[5:2]] <= put_byte(w_mem[fill_reg[5:2]], fill_reg[1:0],
                    (pad_done_reg ? 8'h00 : sha256_pkg::PAD_BYTE));
        end
        else if (state_reg == sha256_pkg::ST_ROUND && round_reg >= 6'd16)
            w_mem[ri] <= w_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256_pkg::ST_IDLE;
            fill_reg     <= '0;
            count_reg    <= '0;
            round_reg    <= '0;
            widx_reg     <= '0;
            final_reg    <= 1'b0;
            len_done_reg <= 1'b0;
            pad_done_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::IV[i];
                v_reg[i] <= sha256_pkg::IV[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sha256_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        final_reg <= last;
                        if (has_byte)
                        begin
                            fill_reg  <= fill_reg + 6'd1;
                            count_reg <= count_reg + 61'd1;
                        end
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                        round_reg <= '0;
                    end
                end
                sha256_pkg::ST_PAD:
                begin
                    // The first pad cycle of a message writes 0x80, later ones write zeros or the length.
                    pad_done_reg <= 1'b1;
                    if (pad_end)
                    begin
                        if (pad_done_reg && fill_reg == sha256_pkg::LEN_POS)
                            len_done_reg <= 1'b1;
                        fill_reg  <= '0;
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                    end
                    else
                        fill_reg <= fill_reg + 6'd1;
                end
                sha256_pkg::ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                sha256_pkg::ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                        v_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    fill_reg <= '0;
                    widx_reg <= '0;
                end
                sha256_pkg::ST_OUT:
                begin
                    if (out_fire)
                        widx_reg <= widx_reg + 2'd1;
                end
                sha256_pkg::ST_ZERO:
                begin
                    fill_reg     <= '0;
                    count_reg    <= '0;
                    final_reg    <= 1'b0;
                    len_done_reg <= 1'b0;
                    pad_done_reg <= 1'b0;
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= sha256_pkg::IV[i];
                end
                default:
                begin
                    fill_reg <= '0;
                end
            endcase
        end
    end

    assign digest_word = {h_reg[{widx_reg, 1'b0}], h_reg[{widx_reg, 1'b1}]};
    assign word_index  = widx_reg;
    assign last_word   = (widx_reg == 2'd3);

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input and output open together");
    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha256_pkg::ST_ROUND && round_reg == 6'd63)
        |=> state_reg == sha256_pkg::ST_FOLD)
        else $error("round sequencer missed fold");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(widx_reg)))
        else $error("digest word changed under stall");
endmodule
